// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the proximity query block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define PPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define PPQ_ASSERT_NEVER(lbl, cond, msg) `PPQ_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/ppq_pkg.sv =====
// ----------------------------------------------------------------------------
// ppq_pkg
// shared constants and types of the point proximity query block
// ----------------------------------------------------------------------------
package ppq_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 20;
  localparam int RAD_W      = 16;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int AD_W       = COORD_BITS + 1;
  localparam int CMP_W      = (AD_W > RAD_W) ? AD_W : RAD_W + 1;
  localparam int SQ_W       = 2 * RAD_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int PT_W       = 3 * COORD_BITS;
  localparam int NUM_AXES   = 3;

  // largest per-axis distance kept for squaring; any larger one lies outside every radius
  localparam logic [CMP_W-1:0] AXIS_LIM = CMP_W'((1 << RAD_W) - 1);

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [PTR_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic             far;
    logic [SUM_W-1:0] sum;
  } lane_t;

endpackage

// ===== src/ppq_in_if.sv =====
// ----------------------------------------------------------------------------
// ppq_in_if
// command channel: mode, point coordinates and query radius
// ----------------------------------------------------------------------------
interface ppq_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              mode;
  logic signed [ppq_pkg::COORD_BITS-1:0]   x_coord;
  logic signed [ppq_pkg::COORD_BITS-1:0]   y_coord;
  logic signed [ppq_pkg::COORD_BITS-1:0]   z_coord;
  logic [ppq_pkg::RAD_W-1:0]               radius;

  modport source (output valid, mode, x_coord, y_coord, z_coord, radius, input ready);
  modport sink   (input valid, mode, x_coord, y_coord, z_coord, radius, output ready);
endinterface

// ===== src/ppq_out_if.sv =====
// ----------------------------------------------------------------------------
// ppq_out_if
// result channel: hit flag, hit index, point count and overflow
// ----------------------------------------------------------------------------
interface ppq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [ppq_pkg::PTR_W-1:0]   hit_index;
  logic [ppq_pkg::CNT_W-1:0]   point_count;
  logic                        overflow;

  modport source (output valid, hit, hit_index, point_count, overflow, input ready);
  modport sink   (input valid, hit, hit_index, point_count, overflow, output ready);
endinterface

// ===== src/ppq_store.sv =====
// ----------------------------------------------------------------------------
// ppq_store
// point memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ppq_store (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [ppq_pkg::PTR_W-1:0]     wr_addr_i,
  input  logic [ppq_pkg::PT_W-1:0]      wr_data_i,
  input  logic                          rd_en_i,
  input  logic [ppq_pkg::PTR_W-1:0]     rd_addr_i,
  output logic [ppq_pkg::PT_W-1:0]      rd_data_o
);

  logic [ppq_pkg::PT_W-1:0] mem_q [ppq_pkg::MAX_POINTS];
  logic [ppq_pkg::PT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/ppq_cell.sv =====
// ----------------------------------------------------------------------------
// ppq_cell
// one axis of the distance chain: holds the query coordinate of its axis,
// adds the squared axis distance to the running sum from its neighbor
// ----------------------------------------------------------------------------
module ppq_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic signed [ppq_pkg::COORD_BITS-1:0] qcoord_i,
  input  logic signed [ppq_pkg::COORD_BITS-1:0] coord_i,
  input  ppq_pkg::lane_t                        lane_i,
  output ppq_pkg::lane_t                        lane_o
);

  logic signed [ppq_pkg::COORD_BITS-1:0] q_q;
  logic signed [ppq_pkg::AD_W-1:0]       diff;
  logic [ppq_pkg::AD_W-1:0]              absd;
  logic                                  far_axis;
  ppq_pkg::tag_t                         tag_a_q;
  logic                                  far_a_q;
  logic [ppq_pkg::SUM_W-1:0]             sum_a_q;
  logic [ppq_pkg::RAD_W-1:0]             absd_a_q;
  logic [ppq_pkg::SQ_W-1:0]              sq;
  ppq_pkg::tag_t                         tag_b_q;
  logic                                  far_b_q;
  logic [ppq_pkg::SUM_W-1:0]             sum_b_q;

  always_comb begin
    diff     = ppq_pkg::AD_W'(coord_i) - ppq_pkg::AD_W'(q_q);
    absd     = diff[ppq_pkg::AD_W-1] ? ppq_pkg::AD_W'(-diff) : ppq_pkg::AD_W'(diff);
    far_axis = ppq_pkg::CMP_W'(absd) > ppq_pkg::AXIS_LIM;
    sq       = absd_a_q * absd_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_q <= qcoord_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= lane_i.tag;
      tag_b_q <= tag_a_q;
    end
  end

  // payload stages, truncated distance only matters when the axis is near
  always_ff @(posedge clk_i) begin
    far_a_q  <= lane_i.far | far_axis;
    sum_a_q  <= lane_i.sum;
    absd_a_q <= ppq_pkg::RAD_W'(absd);
    far_b_q  <= far_a_q;
    sum_b_q  <= sum_a_q + ppq_pkg::SUM_W'(sq);
  end

  assign lane_o = '{tag: tag_b_q, far: far_b_q, sum: sum_b_q};

endmodule

// ===== src/ppq_chain.sv =====
// ----------------------------------------------------------------------------
// ppq_chain
// row of axis cells with input skew so each cell sees its coordinate
// when the running sum reaches it
// ----------------------------------------------------------------------------
module ppq_chain (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic signed [ppq_pkg::COORD_BITS-1:0] qx_i,
  input  logic signed [ppq_pkg::COORD_BITS-1:0] qy_i,
  input  logic signed [ppq_pkg::COORD_BITS-1:0] qz_i,
  input  logic [ppq_pkg::PT_W-1:0]              point_i,
  input  ppq_pkg::tag_t                         tag_i,
  output ppq_pkg::lane_t                        lane_o
);

  localparam int CB = ppq_pkg::COORD_BITS;

  logic signed [CB-1:0] y_dly_q [2];
  logic signed [CB-1:0] z_dly_q [4];
  logic signed [CB-1:0] qc   [ppq_pkg::NUM_AXES];
  logic signed [CB-1:0] pc   [ppq_pkg::NUM_AXES];
  ppq_pkg::lane_t       lane [ppq_pkg::NUM_AXES+1];

  always_ff @(posedge clk_i) begin
    y_dly_q[0] <= point_i[2*CB-1:CB];
    y_dly_q[1] <= y_dly_q[0];
    z_dly_q[0] <= point_i[CB-1:0];
    z_dly_q[1] <= z_dly_q[0];
    z_dly_q[2] <= z_dly_q[1];
    z_dly_q[3] <= z_dly_q[2];
  end

  assign qc[0] = qx_i;
  assign qc[1] = qy_i;
  assign qc[2] = qz_i;
  assign pc[0] = point_i[3*CB-1:2*CB];
  assign pc[1] = y_dly_q[1];
  assign pc[2] = z_dly_q[3];

  assign lane[0] = '{tag: tag_i, far: 1'b0, sum: '0};

  for (genvar i = 0; i < ppq_pkg::NUM_AXES; i++) begin : g_cell
    ppq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (load_i),
      .qcoord_i (qc[i]),
      .coord_i  (pc[i]),
      .lane_i   (lane[i]),
      .lane_o   (lane[i+1])
    );
  end

  assign lane_o = lane[ppq_pkg::NUM_AXES];

endmodule

// ===== src/point_proximity_query.sv =====
// ----------------------------------------------------------------------------
// point_proximity_query
// fixed radius neighbor search over a store of 3-d fixed point points
// ----------------------------------------------------------------------------
// in_i takes one command word: clear, insert a point, query, or no-op (mode 3)
// out_o returns exactly one result word per command, in order
// clear, insert and no-op: the command goes straight to the finish state, from
//   which its result is loaded into the output register before the next command is taken
// query: the stored points stream out of the point memory one per cycle into
//   a row of three axis cells, two register stages each; the result passes
//   through the finish state into the output register after the last point
//   leaves the row, and only then is the next command taken
// an empty store answers a query without a scan, like a clear
// a new command is taken while the last result still waits in the output
//   register; if out_o stalls, a finished result waits and in_i is held off
// reset empties the store and the output register; memory contents are not
//   cleared, entries at or beyond the point count are never read
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_proximity_query (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppq_in_if.sink    in_i,
  ppq_out_if.source out_o
);

  localparam int CNT_W = ppq_pkg::CNT_W;
  localparam int PTR_W = ppq_pkg::PTR_W;

  ppq_pkg::state_e           state_q, state_d;
  ppq_pkg::mode_e            mode;
  logic [CNT_W-1:0]          count_q;
  logic [PTR_W-1:0]          scan_q;
  ppq_pkg::tag_t             rd_tag_q;
  logic [ppq_pkg::SQ_W-1:0]  r2_q;
  logic                      hit_q, hit_d;
  logic [PTR_W-1:0]          hidx_q, hidx_d;
  logic                      res_hit_q, res_ovf_q;
  logic [PTR_W-1:0]          res_idx_q;
  logic                      out_valid_q, out_hit_q, out_ovf_q;
  logic [PTR_W-1:0]          out_idx_q;
  logic [CNT_W-1:0]          out_cnt_q;
  logic                      in_ready, accept, full, last_addr, lane_hit;
  logic                      wr_en, rd_en, load_q, out_load;
  logic [ppq_pkg::PT_W-1:0]  rd_data;
  ppq_pkg::lane_t            chain_lane;

  assign mode      = ppq_pkg::mode_e'(in_i.mode);
  assign in_ready  = (state_q == ppq_pkg::S_IDLE);
  assign accept    = in_i.valid & in_ready;
  assign full      = (count_q == CNT_W'(ppq_pkg::MAX_POINTS));
  assign last_addr = (CNT_W'(scan_q) == count_q - CNT_W'(1));
  assign wr_en     = accept && (mode == ppq_pkg::MODE_INSERT) && !full;
  assign rd_en     = (state_q == ppq_pkg::S_SCAN);
  assign load_q    = accept && (mode == ppq_pkg::MODE_QUERY);
  assign out_load  = (state_q == ppq_pkg::S_FIN) && (!out_valid_q || out_o.ready);

  // strictly inside the radius, points with a far axis never count
  assign lane_hit = chain_lane.tag.valid && !chain_lane.far &&
                    (chain_lane.sum < ppq_pkg::SUM_W'(r2_q));
  assign hit_d    = hit_q | lane_hit;
  assign hidx_d   = lane_hit ? chain_lane.tag.idx : hidx_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppq_pkg::S_IDLE: begin
        if (accept) begin
          if (mode == ppq_pkg::MODE_QUERY && count_q != '0) begin
            state_d = ppq_pkg::S_SCAN;
          end else begin
            state_d = ppq_pkg::S_FIN;
          end
        end
      end
      ppq_pkg::S_SCAN: begin
        if (last_addr) begin
          state_d = ppq_pkg::S_WAIT;
        end
      end
      ppq_pkg::S_WAIT: begin
        if (chain_lane.tag.valid && chain_lane.tag.last) begin
          state_d = ppq_pkg::S_FIN;
        end
      end
      ppq_pkg::S_FIN: begin
        if (out_load) begin
          state_d = ppq_pkg::S_IDLE;
        end
      end
      default: state_d = ppq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_q      <= '0;
      rd_tag_q    <= '0;
      hit_q       <= 1'b0;
      hidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && mode == ppq_pkg::MODE_CLEAR) begin
        count_q <= '0;
      end else if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (load_q) begin
        scan_q <= '0;
      end else if (rd_en) begin
        scan_q <= scan_q + PTR_W'(1);
      end
      rd_tag_q <= '{valid: rd_en, last: last_addr, idx: scan_q};
      if (load_q) begin
        hit_q  <= 1'b0;
        hidx_q <= '0;
      end else begin
        hit_q  <= hit_d;
        hidx_q <= hidx_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_q) begin
      r2_q <= in_i.radius * in_i.radius;
    end
    if (accept) begin
      res_hit_q <= 1'b0;
      res_idx_q <= '0;
      res_ovf_q <= (mode == ppq_pkg::MODE_INSERT) && full;
    end else if (state_q == ppq_pkg::S_WAIT && chain_lane.tag.valid && chain_lane.tag.last) begin
      res_hit_q <= hit_d;
      res_idx_q <= hidx_d;
    end
    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_idx_q <= res_idx_q;
      out_cnt_q <= count_q;
      out_ovf_q <= res_ovf_q;
    end
  end

  ppq_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[PTR_W-1:0]),
    .wr_data_i ({in_i.x_coord, in_i.y_coord, in_i.z_coord}),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q),
    .rd_data_o (rd_data)
  );

  ppq_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load_q),
    .qx_i    (in_i.x_coord),
    .qy_i    (in_i.y_coord),
    .qz_i    (in_i.z_coord),
    .point_i (rd_data),
    .tag_i   (rd_tag_q),
    .lane_o  (chain_lane)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.hit_index   = out_idx_q;
  assign out_o.point_count = out_cnt_q;
  assign out_o.overflow    = out_ovf_q;

  `PPQ_ASSERT(a_count_bound, count_q <= CNT_W'(ppq_pkg::MAX_POINTS), "point count above capacity")
  `PPQ_ASSERT(a_lane_in_query, chain_lane.tag.valid |-> (state_q == ppq_pkg::S_SCAN || state_q == ppq_pkg::S_WAIT), "chain word outside a query")
  `PPQ_ASSERT(a_insert_grows, wr_en |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not advance count")
  `PPQ_ASSERT_NEVER(a_out_from_fin, $rose(out_valid_q) && !$past(state_q == ppq_pkg::S_FIN), "result loaded outside finish")

endmodule
